### src/cc3p_pkg.sv
// Package: widths, types and shared constants for the circumcircle block
`timescale 1ns / 1ps
package cc3p_pkg;
	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int IN_W           = 12;
	localparam int OUT_W          = 32;
	// numerator/denominator working widths (fits COORD_BITS up to 16)
	localparam int NUM_W  = 56;
	localparam int DEN_W  = 36;
	// quotient bits produced by the divider chain: 34 integer + FRAC_BITS fraction
	localparam int QI_W   = 34;
	localparam int SQ_W   = 66;
	localparam int RAD_W  = 33;
	localparam logic [OUT_W:0] POS_LIM = 33'h0_7FFF_FFFF;
	localparam logic [OUT_W:0] NEG_LIM = 33'h0_8000_0000;
	localparam logic [OUT_W-1:0] RAD_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [IN_W-1:0] first_x;
		logic [IN_W-1:0] first_y;
		logic [IN_W-1:0] second_x;
		logic [IN_W-1:0] second_y;
		logic [IN_W-1:0] third_x;
		logic [IN_W-1:0] third_y;
	} pts_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] center_x;
		logic signed [OUT_W-1:0] center_y;
		logic [OUT_W-1:0]        radius;
		logic                    degenerate;
		logic                    saturated;
	} circ_t;

	// division cell state: remainder, divisor, quotient bits so far
	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [NUM_W-1:0] quo;
	} dv_t;

	// square root cell state: remaining value, root so far
	typedef struct packed {
		logic [SQ_W-1:0]  rem;
		logic [RAD_W-1:0] root;
	} sq_t;
endpackage

### src/cc3p_if.sv
// Interfaces: valid/ready channels for points and circles
`timescale 1ns / 1ps
interface cc3p_pts_if;
	logic              valid;
	logic              ready;
	cc3p_pkg::pts_t    data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface cc3p_circ_if;
	logic              valid;
	logic              ready;
	cc3p_pkg::circ_t   data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### src/cc3p_div_cell.sv
// Cell: one restoring division step, unsigned magnitudes
`timescale 1ns / 1ps
module cc3p_div_cell (
	input  logic           clk,
	input  logic           en,
	input  cc3p_pkg::dv_t  din,
	output cc3p_pkg::dv_t  dout
);
	logic [cc3p_pkg::NUM_W:0] sh;
	logic [cc3p_pkg::NUM_W:0] df;
	cc3p_pkg::dv_t            nxt;

	always_comb begin
		nxt = din;
		sh  = {din.rem, din.quo[cc3p_pkg::NUM_W-1]};
		df  = sh - {{(cc3p_pkg::NUM_W-cc3p_pkg::DEN_W+1){1'b0}}, din.den};
		if (!df[cc3p_pkg::NUM_W]) begin
			nxt.rem = df[cc3p_pkg::NUM_W-1:0];
			nxt.quo = {din.quo[cc3p_pkg::NUM_W-2:0], 1'b1};
		end else begin
			nxt.rem = sh[cc3p_pkg::NUM_W-1:0];
			nxt.quo = {din.quo[cc3p_pkg::NUM_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end
endmodule

### src/cc3p_sqrt_cell.sv
// Cell: one digit-by-digit square root step
`timescale 1ns / 1ps
module cc3p_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           en,
	input  cc3p_pkg::sq_t  din,
	output cc3p_pkg::sq_t  dout
);
	localparam int SH = 2 * STEP;
	logic [cc3p_pkg::SQ_W-1:0] trial;
	cc3p_pkg::sq_t             nxt;

	always_comb begin
		nxt   = din;
		trial = (cc3p_pkg::SQ_W'(din.root) << (SH + 2)) | (cc3p_pkg::SQ_W'(1) << SH);
		if (din.rem >= trial) begin
			nxt.rem  = din.rem - trial;
			nxt.root = {din.root[cc3p_pkg::RAD_W-2:0], 1'b1};
		end else begin
			nxt.root = {din.root[cc3p_pkg::RAD_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end
endmodule

### src/circumcircle_three_points.sv
// Top level: pipelined circumcircle of three pixel points
//
//  channel | dir | payload
//  pts     | in  | first_x..third_y, 12 bits each
//  circ    | out | center_x, center_y, radius, degenerate, saturated
//
//  One item per cycle while the output is not stalled; QBITS = 34 + FRAC_BITS (42 by default).
//  Depth is set by the chain of division cells (one quotient bit each, both
//  centers in parallel) and the chain of square root cells (one root bit each).
//  The whole chain advances together when the output stage is free or taken.
//  Reset clears only the valid bits of the stages.
`timescale 1ns / 1ps
module circumcircle_three_points #(
	parameter int COORD_BITS = cc3p_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = cc3p_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	cc3p_pts_if.sink    pts,
	cc3p_circ_if.source circ
);
	localparam int NW    = cc3p_pkg::NUM_W;
	localparam int DW    = cc3p_pkg::DEN_W;
	localparam int QBITS = cc3p_pkg::QI_W + FRAC_BITS;
	localparam int NSQ   = cc3p_pkg::RAD_W;
	localparam int DEPTH = 4 + QBITS + 2 + NSQ;
	localparam logic [17:0] CMASK = 18'((1 << COORD_BITS) - 1);

	logic [DEPTH-1:0] vld_q;
	logic             adv;
	assign adv       = !circ.valid || circ.ready;
	assign pts.ready = adv;

	// stage 1: coordinates, masked to COORD_BITS
	logic signed [17:0] x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s1 <= 18'(pts.data.first_x) & CMASK;
			y1_s1 <= 18'(pts.data.first_y) & CMASK;
			x2_s1 <= 18'(pts.data.second_x) & CMASK;
			y2_s1 <= 18'(pts.data.second_y) & CMASK;
			x3_s1 <= 18'(pts.data.third_x) & CMASK;
			y3_s1 <= 18'(pts.data.third_y) & CMASK;
		end
	end

	// stage 2: squared norms, differences and denominator
	logic signed [35:0] s1_s2, s2_s2, s3_s2, den_s2;
	logic signed [17:0] dy1_s2, dy2_s2, dy3_s2, dx1_s2, dx2_s2, dx3_s2;
	logic signed [17:0] x1_s2, y1_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			s1_s2  <= 36'(x1_s1 * x1_s1) + 36'(y1_s1 * y1_s1);
			s2_s2  <= 36'(x2_s1 * x2_s1) + 36'(y2_s1 * y2_s1);
			s3_s2  <= 36'(x3_s1 * x3_s1) + 36'(y3_s1 * y3_s1);
			den_s2 <= 36'((x2_s1 - x1_s1) * (y3_s1 - y1_s1))
				- 36'((x3_s1 - x1_s1) * (y2_s1 - y1_s1));
			dy1_s2 <= y2_s1 - y3_s1;
			dy2_s2 <= y3_s1 - y1_s1;
			dy3_s2 <= y1_s1 - y2_s1;
			dx1_s2 <= x3_s1 - x2_s1;
			dx2_s2 <= x1_s1 - x3_s1;
			dx3_s2 <= x2_s1 - x1_s1;
			x1_s2  <= x1_s1;
			y1_s2  <= y1_s1;
		end
	end

	// stage 3: numerators and doubled denominator
	logic signed [NW-1:0] nx_s3, ny_s3;
	logic signed [DW-1:0] den_s3;
	logic signed [17:0]   x1_s3, y1_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s3  <= NW'(s1_s2 * dy1_s2) + NW'(s2_s2 * dy2_s2) + NW'(s3_s2 * dy3_s2);
			ny_s3  <= NW'(s1_s2 * dx1_s2) + NW'(s2_s2 * dx2_s2) + NW'(s3_s2 * dx3_s2);
			den_s3 <= DW'(den_s2 <<< 1);
			x1_s3  <= x1_s2;
			y1_s3  <= y1_s2;
		end
	end

	// stage 4: magnitudes and signs into the division chain
	cc3p_pkg::dv_t dvx [QBITS+1];
	cc3p_pkg::dv_t dvy [QBITS+1];
	logic [QBITS:0] negx_q, negy_q, dgn_q;
	logic [QBITS:0] ovx_q, ovy_q;
	logic signed [17:0] px1_q [QBITS+1];
	logic signed [17:0] py1_q [QBITS+1];
	logic [DW-1:0] dmag;
	logic [NW-1:0] nmx, nmy;
	assign dmag = den_s3[DW-1] ? DW'(-den_s3) : DW'(den_s3);
	assign nmx  = nx_s3[NW-1] ? NW'(-nx_s3) : NW'(nx_s3);
	assign nmy  = ny_s3[NW-1] ? NW'(-ny_s3) : NW'(ny_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			dvx[0].rem <= '0;
			dvx[0].den <= dmag;
			dvx[0].quo <= nmx;
			dvy[0].rem <= '0;
			dvy[0].den <= dmag;
			dvy[0].quo <= nmy;
			negx_q[0]  <= nx_s3[NW-1] ^ den_s3[DW-1];
			negy_q[0]  <= ny_s3[NW-1] ^ den_s3[DW-1];
			ovx_q[0]   <= (nmx >> cc3p_pkg::QI_W) >= NW'(dmag);
			ovy_q[0]   <= (nmy >> cc3p_pkg::QI_W) >= NW'(dmag);
			dgn_q[0]   <= den_s3 == '0;
			px1_q[0]   <= x1_s3;
			py1_q[0]   <= y1_s3;
		end
	end

	// dividend is shifted left FRAC_BITS: feed numerator bits then FRAC_BITS zeros.
	// The chain runs NW + FRAC_BITS steps in principle; integer part above
	// QI_W bits only matters as overflow, caught by the leading-bit check.
	localparam int LEAD = NW - cc3p_pkg::QI_W;

	genvar gi;
	generate
		for (gi = 0; gi < QBITS; gi++) begin : g_div
			cc3p_pkg::dv_t sx, sy;
			always_comb begin
				sx = dvx[gi];
				sy = dvy[gi];
				if (gi == 0) begin
					sx.rem = NW'(dvx[0].quo >> cc3p_pkg::QI_W);
					sx.quo = dvx[0].quo << LEAD;
					sy.rem = NW'(dvy[0].quo >> cc3p_pkg::QI_W);
					sy.quo = dvy[0].quo << LEAD;
				end
			end
			cc3p_div_cell u_dx (.clk(clk), .en(adv), .din(sx), .dout(dvx[gi+1]));
			cc3p_div_cell u_dy (.clk(clk), .en(adv), .din(sy), .dout(dvy[gi+1]));
			always_ff @(posedge clk) begin
				if (adv) begin
					negx_q[gi+1] <= negx_q[gi];
					negy_q[gi+1] <= negy_q[gi];
					ovx_q[gi+1]  <= ovx_q[gi];
					ovy_q[gi+1]  <= ovy_q[gi];
					dgn_q[gi+1]  <= dgn_q[gi];
					px1_q[gi+1]  <= px1_q[gi];
					py1_q[gi+1]  <= py1_q[gi];
				end
			end
		end
	endgenerate

	// saturate centers, form offsets
	logic [NW-1:0] qx, qy;
	logic [cc3p_pkg::OUT_W:0] mx, my;
	logic sx_c, sy_c;
	logic signed [cc3p_pkg::OUT_W-1:0] cx_c, cy_c;
	always_comb begin
		qx   = dvx[QBITS].quo & ((NW'(1) << QBITS) - NW'(1));
		qy   = dvy[QBITS].quo & ((NW'(1) << QBITS) - NW'(1));
		sx_c = 1'b0;
		sy_c = 1'b0;
		if (ovx_q[QBITS]
				|| qx > NW'(negx_q[QBITS] ? cc3p_pkg::NEG_LIM : cc3p_pkg::POS_LIM)) begin
			mx   = negx_q[QBITS] ? cc3p_pkg::NEG_LIM : cc3p_pkg::POS_LIM;
			sx_c = 1'b1;
		end else begin
			mx = qx[cc3p_pkg::OUT_W:0];
		end
		if (ovy_q[QBITS]
				|| qy > NW'(negy_q[QBITS] ? cc3p_pkg::NEG_LIM : cc3p_pkg::POS_LIM)) begin
			my   = negy_q[QBITS] ? cc3p_pkg::NEG_LIM : cc3p_pkg::POS_LIM;
			sy_c = 1'b1;
		end else begin
			my = qy[cc3p_pkg::OUT_W:0];
		end
		cx_c = negx_q[QBITS] ? cc3p_pkg::OUT_W'(-mx) : cc3p_pkg::OUT_W'(mx);
		cy_c = negy_q[QBITS] ? cc3p_pkg::OUT_W'(-my) : cc3p_pkg::OUT_W'(my);
	end

	// stage: centers and absolute offsets from the first point
	logic signed [cc3p_pkg::OUT_W-1:0] cx_r, cy_r;
	logic [33:0] ax_r, ay_r;
	logic        sat_r, dgn_r;
	logic signed [34:0] ddx, ddy;
	assign ddx = 35'(cx_c) - (35'(px1_q[QBITS]) <<< FRAC_BITS);
	assign ddy = 35'(cy_c) - (35'(py1_q[QBITS]) <<< FRAC_BITS);
	always_ff @(posedge clk) begin
		if (adv) begin
			cx_r  <= cx_c;
			cy_r  <= cy_c;
			ax_r  <= ddx[34] ? 34'(-ddx) : 34'(ddx);
			ay_r  <= ddy[34] ? 34'(-ddy) : 34'(ddy);
			sat_r <= sx_c | sy_c;
			dgn_r <= dgn_q[QBITS];
		end
	end

	cc3p_pkg::sq_t sq [NSQ+1];
	logic signed [cc3p_pkg::OUT_W-1:0] pcx_q [NSQ+1];
	logic signed [cc3p_pkg::OUT_W-1:0] pcy_q [NSQ+1];
	logic [NSQ:0] psat_q, pdgn_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			sq[0].rem  <= cc3p_pkg::SQ_W'(68'(ax_r) * 68'(ax_r) + 68'(ay_r) * 68'(ay_r));
			sq[0].root <= '0;
			pcx_q[0]   <= cx_r;
			pcy_q[0]   <= cy_r;
			psat_q[0]  <= sat_r;
			pdgn_q[0]  <= dgn_r;
		end
	end

	generate
		for (gi = 0; gi < NSQ; gi++) begin : g_sq
			cc3p_sqrt_cell #(.STEP(NSQ-1-gi)) u_sq (
				.clk(clk), .en(adv), .din(sq[gi]), .dout(sq[gi+1]));
			always_ff @(posedge clk) begin
				if (adv) begin
					pcx_q[gi+1]  <= pcx_q[gi];
					pcy_q[gi+1]  <= pcy_q[gi];
					psat_q[gi+1] <= psat_q[gi];
					pdgn_q[gi+1] <= pdgn_q[gi];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], pts.valid};
		end
	end

	logic rsat;
	assign rsat = sq[NSQ].root[cc3p_pkg::RAD_W-1];
	assign circ.valid = vld_q[DEPTH-1];
	always_comb begin
		circ.data.degenerate = pdgn_q[NSQ];
		if (pdgn_q[NSQ]) begin
			circ.data.center_x  = '0;
			circ.data.center_y  = '0;
			circ.data.radius    = '0;
			circ.data.saturated = 1'b0;
		end else begin
			circ.data.center_x  = pcx_q[NSQ];
			circ.data.center_y  = pcy_q[NSQ];
			circ.data.radius    = rsat ? cc3p_pkg::RAD_MAX
				: sq[NSQ].root[cc3p_pkg::OUT_W-1:0];
			circ.data.saturated = psat_q[NSQ] | rsat;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		circ.valid && !circ.ready |=> circ.valid)
		else $error("output item dropped under stall");
	a_dgn: assert property (@(posedge clk) disable iff (!arst_n)
		circ.valid && circ.data.degenerate |-> !circ.data.saturated)
		else $error("degenerate item marked saturated");
	a_frz: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline moved while stalled");
endmodule
